@@ hw/rtl/pbf_pkg.sv @@
// ----------------------------------------------------------------------------
// pbf_pkg: shared types and constants for the prefix border function block
// Holds the capacity, derived widths, controller states and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package pbf_pkg;

   localparam int MAX_LEN = 4096;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 8;
   localparam int OUT_W   = 12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FETCH,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;    // latch incoming item
      logic start;     // first pass: read previous border or finish at once
      logic link;      // follow one failure link
      logic finish;    // settle border, write stores
      logic load_out;  // move result into output register
   } cmd_type;

   typedef struct packed {
      logic overflow;  // position at or beyond capacity
      logic pos_zero;  // first symbol of a string
      logic more;      // mismatch with border left: keep following links
      logic out_free;  // output register can take a result
   } status_type;

endpackage

@@ hw/rtl/pbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbf_ctrl: sequencer for the prefix border function
// Steps one item through start, link walk and result hand-off.
// ----------------------------------------------------------------------------
module pbf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pbf_pkg::status_type status,
   output pbf_pkg::cmd_type    cmd
);

   pbf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbf_pkg::ST_IDLE: begin
            if (req_valid) state_in = pbf_pkg::ST_START;
         end
         pbf_pkg::ST_START: begin
            if (status.overflow || status.pos_zero) state_in = pbf_pkg::ST_DONE;
            else                                    state_in = pbf_pkg::ST_FETCH;
         end
         pbf_pkg::ST_FETCH: begin
            state_in = pbf_pkg::ST_CMP;
         end
         pbf_pkg::ST_CMP: begin
            if (!status.more) state_in = pbf_pkg::ST_DONE;
         end
         pbf_pkg::ST_DONE: begin
            if (status.out_free) state_in = pbf_pkg::ST_IDLE;
         end
         default: begin
            state_in = pbf_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pbf_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         pbf_pkg::ST_START: begin
            cmd.start = 1'b1;
         end
         pbf_pkg::ST_FETCH: begin
            cmd.link = 1'b1;
         end
         pbf_pkg::ST_CMP: begin
            cmd.link   = status.more;
            cmd.finish = !status.more;
         end
         pbf_pkg::ST_DONE: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/pbf_dp.sv @@
// ----------------------------------------------------------------------------
// pbf_dp: datapath for the prefix border function
// Symbol and border stores, link walk registers and the output register.
// ----------------------------------------------------------------------------
module pbf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  pbf_pkg::cmd_type                    cmd,
   output pbf_pkg::status_type                 status,
   input  logic [pbf_pkg::SYM_W-1:0]           req_symbol,
   input  logic                                req_first,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbf_pkg::OUT_W-1:0]           rsp_border_len,
   output logic [pbf_pkg::OUT_W-1:0]           rsp_position,
   output logic                                rsp_overflow
);

   localparam int AW = pbf_pkg::ADDR_W;
   localparam int PW = pbf_pkg::POS_W;
   localparam int SW = pbf_pkg::SYM_W;
   localparam int OW = pbf_pkg::OUT_W;

   logic [SW-1:0] sym_mem [pbf_pkg::MAX_LEN];
   logic [AW-1:0] bt_mem  [pbf_pkg::MAX_LEN];

   logic [SW-1:0] sym_ff;
   logic [PW-1:0] pos_ff, next_pos_ff;
   logic [AW-1:0] k_ff, k_in;
   logic [SW-1:0] sym_rd_ff;
   logic [AW-1:0] bt_rd_ff;
   logic          rsp_valid_ff;
   logic [OW-1:0] rsp_border_ff, rsp_pos_ff;
   logic          rsp_ovf_ff;

   logic          ovf, k_below, mismatch, wr_en;
   logic [AW-1:0] sym_raddr, bt_raddr, k_final;

   assign ovf      = (pos_ff >= PW'(pbf_pkg::MAX_LEN));
   assign k_below  = ({1'b0, k_ff} < pos_ff);
   assign mismatch = (sym_rd_ff != sym_ff);
   assign k_final  = (k_below && !mismatch) ? (k_ff + AW'(1)) : '0;

   assign status.overflow = ovf;
   assign status.pos_zero = (pos_ff == '0);
   assign status.more     = (k_ff != '0) && k_below && mismatch;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // read addresses: previous border on start, else walk from last border read
   assign bt_raddr  = cmd.start ? AW'(pos_ff - PW'(1)) : (bt_rd_ff - AW'(1));
   assign sym_raddr = bt_rd_ff;

   assign wr_en = (cmd.start && !ovf && (pos_ff == '0)) || cmd.finish;

   always_comb begin
      k_in = k_ff;
      if (cmd.start)       k_in = '0;
      else if (cmd.link)   k_in = bt_rd_ff;
      else if (cmd.finish) k_in = k_final;
   end

   always_ff @(posedge clock) begin
      if (wr_en) sym_mem[pos_ff[AW-1:0]] <= sym_ff;
      sym_rd_ff <= sym_mem[sym_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) bt_mem[pos_ff[AW-1:0]] <= k_in;
      bt_rd_ff <= bt_mem[bt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff <= req_symbol;
         pos_ff <= req_first ? '0 : next_pos_ff;
      end
      k_ff <= k_in;
      if (cmd.load_out) begin
         rsp_border_ff <= OW'(k_ff);
         rsp_pos_ff    <= ovf ? '0 : OW'(pos_ff);
         rsp_ovf_ff    <= ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) next_pos_ff <= pos_ff + PW'(1);
         if (cmd.load_out)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_border_len = rsp_border_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

@@ hw/rtl/prefix_border_function.sv @@
// ----------------------------------------------------------------------------
// prefix_border_function: streaming prefix (failure) function of a string
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per byte of the string (req_symbol), with req_first
//   high on the byte that opens a new string. After reset the first byte
//   opens a string even without req_first.
//   rsp_ channel: one item per request item: rsp_border_len is the longest
//   proper border of the prefix ending at this byte, rsp_position its index.
//   Bytes past the 4096-byte capacity are not stored; they return
//   rsp_overflow = 1 with border and position zero.
// Sequencing:
//   One item is in flight at a time. An item that opens a string or
//   overflows goes from ST_START straight to ST_DONE; any other passes
//   through ST_FETCH and ST_CMP, which repeats while failure links remain,
//   each link being one read of the single read port of the symbol and
//   border stores. The result is loaded into the output register in ST_DONE
//   once that register is free; the next item is accepted after the load.
//   Links amortize to at most one per byte over a string.
// Reset: clears the sequencer, the result-valid flag and the write position;
//   the stores keep stale data that is never read before being written.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile, and its result waits until the register is taken.
// ----------------------------------------------------------------------------
module prefix_border_function (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pbf_pkg::SYM_W-1:0]        req_symbol,
   input  logic                             req_first,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pbf_pkg::OUT_W-1:0]        rsp_border_len,
   output logic [pbf_pkg::OUT_W-1:0]        rsp_position,
   output logic                             rsp_overflow
);

   pbf_pkg::cmd_type    cmd;
   pbf_pkg::status_type status;

   // sequencer: steps each item through start, link walk and hand-off
   pbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: stores, walk registers, output register
   pbf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_symbol     (req_symbol),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_border_len (rsp_border_len),
      .rsp_position   (rsp_position),
      .rsp_overflow   (rsp_overflow)
   );

   // an overflow result carries no border and no position
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_border_len == '0) && (rsp_position == '0))
      else $error("overflow result with nonzero border or position");

   // a proper border is shorter than the prefix it belongs to
   a_border_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |->
         (rsp_border_len <= rsp_position) || (rsp_border_len == '0))
      else $error("border not shorter than prefix");

   // one item at a time: no acceptance right after an acceptance
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   // a result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a waiting result");

endmodule
